FILE: hw/rtl/halton_radical_inverse_defines.svh
// assertion helpers shared by the halton radical inverse rtl
// both expect signals named clk and rst_n in the enclosing module
`ifndef HALTON_RADICAL_INVERSE_DEFINES_SVH
`define HALTON_RADICAL_INVERSE_DEFINES_SVH

// same-cycle implication
`define HRI_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HRI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/hri_pkg.sv
package hri_pkg;

  localparam int INDEX_W  = 31;
  localparam int BASE_W   = 8;
  localparam int FRAC_W   = 32;
  // b^digits stays below 2^31 * 255 < 2^39
  localparam int MIRROR_W = 39;

  localparam int DEFAULT_FRACTION_BITS = 32;

  // digit divider: quotient bits per cycle and cycles per digit
  localparam int DIV_STEPS  = 4;
  localparam int DIV_CYCLES = 8;
  localparam int DIV_W      = DIV_STEPS * DIV_CYCLES;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_DIGIT,
    ST_FRAC,
    ST_DONE
  } hri_state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic digit_upd;
    logic frac_step;
    logic out_load;
  } hri_cmd_t;

  typedef struct packed {
    logic skip;     // index zero or base below two at load
    logic q_zero;   // quotient after a digit is zero
  } hri_status_t;

endpackage

FILE: hw/rtl/hri_datapath.sv
module hri_datapath
  import hri_pkg::*;
(
  input  logic              clk,
  input  logic [INDEX_W-1:0] in_index,
  input  logic [BASE_W-1:0]  in_base,
  input  hri_cmd_t          cmd,
  output hri_status_t       status,
  output logic [FRAC_W-1:0] out_fraction
);

  logic [DIV_W-1:0]    div_r, div_nxt;
  logic [BASE_W-1:0]   drem_r, drem_nxt;
  logic [BASE_W-1:0]   base_r, base_nxt;
  logic [MIRROR_W-1:0] mir_r, mir_nxt;
  logic [MIRROR_W-1:0] den_r, den_nxt;
  logic [FRAC_W-1:0]   q_r, q_nxt;
  logic [FRAC_W-1:0]   out_fraction_r, out_fraction_nxt;

  logic [DIV_W-1:0]           step_div;
  logic [BASE_W-1:0]          step_rem;
  logic [BASE_W:0]            trial;
  logic [MIRROR_W+BASE_W-1:0] mir_prod;
  logic [MIRROR_W+BASE_W-1:0] den_prod;
  logic [MIRROR_W:0]          frac_trial;

  // DIV_STEPS restoring division steps of the dividend by the base
  always_comb begin
    step_div = div_r;
    step_rem = drem_r;
    trial    = '0;
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial    = {step_rem, step_div[DIV_W-1]};
      step_div = {step_div[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, base_r}) begin
        step_rem    = BASE_W'(trial - {1'b0, base_r});
        step_div[0] = 1'b1;
      end else begin
        step_rem = trial[BASE_W-1:0];
      end
    end
  end

  assign mir_prod   = (MIRROR_W+BASE_W)'(mir_r) * (MIRROR_W+BASE_W)'(base_r);
  assign den_prod   = (MIRROR_W+BASE_W)'(den_r) * (MIRROR_W+BASE_W)'(base_r);
  assign frac_trial = {mir_r, 1'b0};

  always_comb begin
    div_nxt          = div_r;
    drem_nxt         = drem_r;
    base_nxt         = base_r;
    mir_nxt          = mir_r;
    den_nxt          = den_r;
    q_nxt            = q_r;
    out_fraction_nxt = out_fraction_r;
    if (cmd.load) begin
      div_nxt  = DIV_W'(in_index);
      drem_nxt = '0;
      base_nxt = in_base;
      mir_nxt  = '0;
      den_nxt  = MIRROR_W'(1);
      q_nxt    = '0;
    end
    if (cmd.div_step) begin
      div_nxt  = step_div;
      drem_nxt = step_rem;
    end
    // append the extracted digit; the quotient stays in div_r as the next dividend
    if (cmd.digit_upd) begin
      mir_nxt  = MIRROR_W'(mir_prod) + MIRROR_W'(drem_r);
      den_nxt  = MIRROR_W'(den_prod);
      drem_nxt = '0;
    end
    // long division of mirrored digits by base^digits, one fraction bit a cycle
    if (cmd.frac_step) begin
      if (frac_trial >= {1'b0, den_r}) begin
        mir_nxt = MIRROR_W'(frac_trial - {1'b0, den_r});
        q_nxt   = {q_r[FRAC_W-2:0], 1'b1};
      end else begin
        mir_nxt = frac_trial[MIRROR_W-1:0];
        q_nxt   = {q_r[FRAC_W-2:0], 1'b0};
      end
    end
    if (cmd.out_load) begin
      out_fraction_nxt = q_r;
    end
  end

  always_ff @(posedge clk) begin
    div_r          <= div_nxt;
    drem_r         <= drem_nxt;
    base_r         <= base_nxt;
    mir_r          <= mir_nxt;
    den_r          <= den_nxt;
    q_r            <= q_nxt;
    out_fraction_r <= out_fraction_nxt;
  end

  assign status.skip   = (in_index == '0) || (in_base < BASE_W'(2));
  assign status.q_zero = (div_r == '0);
  assign out_fraction  = out_fraction_r;

endmodule

FILE: hw/rtl/hri_controller.sv
`include "halton_radical_inverse_defines.svh"

module hri_controller
  import hri_pkg::*;
#(
  parameter int FRACTION_BITS = DEFAULT_FRACTION_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  hri_status_t status,
  output hri_cmd_t    cmd
);

  localparam int CNT_W = $clog2(FRACTION_BITS);

  hri_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = status.skip ? ST_FRAC : ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DIV_CYCLES - 1)) begin
          state_nxt = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        cmd.digit_upd = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = status.q_zero ? ST_FRAC : ST_DIVIDE;
      end
      ST_FRAC: begin
        cmd.frac_step = 1'b1;
        cnt_nxt       = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(FRACTION_BITS - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // hand over once the output register is free or being drained
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

  `HRI_ASSERT_NEXT(a_accept_leaves_idle, in_valid && in_ready, state_r != ST_IDLE,
                   "accepted transaction did not start work")
  `HRI_ASSERT_NEXT(a_digit_after_divide,
                   state_r == ST_DIVIDE && cnt_r == CNT_W'(DIV_CYCLES - 1),
                   state_r == ST_DIGIT, "digit division did not end on schedule")
  `HRI_ASSERT(a_frac_count_bound, state_r == ST_FRAC,
              cnt_r <= CNT_W'(FRACTION_BITS - 1), "fraction step count overran")
  `HRI_ASSERT(a_result_from_done, $rose(out_valid_r), $past(state_r) == ST_DONE,
              "result raised outside the done state")

endmodule

FILE: hw/rtl/halton_radical_inverse.sv
// Halton radical inverse: in_index's base-in_base digits mirrored behind the
// radix point, returned as an unsigned 0.32 fixed-point fraction, truncated.
// Input channel in_valid/in_ready carries in_index (31 bits) and in_base
// (8 bits, 2 to 255); result channel out_valid/out_ready carries out_fraction.
// One result per transaction, no state kept between transactions.
// From acceptance, each base-b digit of the index is produced by a
// 4-bit-per-cycle divider and then folded into the numerator until the
// quotient is zero (an index of zero or a base below two has no digits);
// the fraction then comes out of a one-bit-per-cycle restoring divider.
// One transaction is in flight at a time; in_ready is high while the
// controller is idle, so the next index can enter while a finished result
// still sits in the output register.
// Reset (rst_n low, synchronous) drops out_valid and returns to idle.
// If the receiver stalls, the finished result holds in the output register
// and a following result waits in the datapath until that register drains.
module halton_radical_inverse
  import hri_pkg::*;
#(
  parameter int FRACTION_BITS = DEFAULT_FRACTION_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [INDEX_W-1:0] in_index,
  input  logic [BASE_W-1:0]  in_base,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [FRAC_W-1:0]  out_fraction
);

  hri_cmd_t    cmd;
  hri_status_t status;

  hri_controller #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status   (status),
    .cmd      (cmd)
  );

  hri_datapath u_dp (
    .clk         (clk),
    .in_index    (in_index),
    .in_base     (in_base),
    .cmd         (cmd),
    .status      (status),
    .out_fraction(out_fraction)
  );

endmodule
